[hdl/bezier_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier evaluator package
// Shared widths, request codes and the command bundle that the sequencer
// drives into the arithmetic datapath.
// ----------------------------------------------------------------------------
package bezier_pkg;

   localparam int CNT_W   = 4;
   localparam int IDX_IN_W = 3;
   localparam int IN_W    = 32;
   localparam int T_W     = 17;
   localparam int OUT_W   = 48;
   localparam int SCALE_W = 8;

   localparam logic [T_W-1:0]   T_ONE      = 17'h10000;
   localparam logic [15:0]      ROUND_HALF = 16'h8000;
   localparam logic [OUT_W-1:0] OUT_MAX    = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_MIN    = {1'b1, {(OUT_W-1){1'b0}}};

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   localparam logic [1:0] ORDER_POINT  = 2'd0;
   localparam logic [1:0] ORDER_FIRST  = 2'd1;
   localparam logic [1:0] ORDER_SECOND = 2'd2;
   localparam logic [1:0] ORDER_NONE   = 2'd3;

   typedef enum logic {
      OP_DIFF,
      OP_LERP
   } op_type;

   typedef struct packed {
      logic               store_wr;
      logic               load_row;
      logic               do_sub;
      logic               do_mul;
      logic               do_add;
      op_type             op;
      logic [SCALE_W-1:0] scale;
      logic [CNT_W-1:0]   wr_pos;
      logic               shift2;
      logic               load_out;
      logic               zero_out;
   } cmd_type;

endpackage

[hdl/bezier_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier evaluator datapath
// Control point store, one working row per coordinate and a shared
// subtract, multiply and add unit per coordinate, plus the result register.
// ----------------------------------------------------------------------------
module bezier_dp #(
   parameter int MAX_POINTS = 8,
   parameter int COORD_BITS = 32
) (
   input  logic                                clock,
   input  bezier_pkg::cmd_type                 cmd,
   input  logic [bezier_pkg::IDX_IN_W-1:0]     req_point_index,
   input  logic [bezier_pkg::IN_W-1:0]         req_coord_x,
   input  logic [bezier_pkg::IN_W-1:0]         req_coord_y,
   input  logic [bezier_pkg::IN_W-1:0]         req_coord_z,
   input  logic [bezier_pkg::T_W-1:0]          req_param_t,
   output logic [bezier_pkg::OUT_W-1:0]        rsp_out_x,
   output logic [bezier_pkg::OUT_W-1:0]        rsp_out_y,
   output logic [bezier_pkg::OUT_W-1:0]        rsp_out_z
);
   import bezier_pkg::*;

   localparam int P      = MAX_POINTS;
   localparam int W      = COORD_BITS + 10;
   localparam int WIDE_W = 48;
   localparam int LANES  = 3;

   logic [T_W-1:0]   t_ff;
   logic [T_W-1:0]   mul_op;
   logic [IN_W-1:0]  coord_in [LANES];
   logic [OUT_W-1:0] lane_out [LANES];

   assign coord_in[0] = req_coord_x;
   assign coord_in[1] = req_coord_y;
   assign coord_in[2] = req_coord_z;

   assign rsp_out_x = lane_out[0];
   assign rsp_out_y = lane_out[1];
   assign rsp_out_z = lane_out[2];

   always_ff @(posedge clock) begin
      if (cmd.load_row) begin
         t_ff <= (req_param_t > T_ONE) ? T_ONE : req_param_t;
      end
   end

   assign mul_op = (cmd.op == OP_LERP) ? t_ff : T_W'(cmd.scale);

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [WIDE_W-1:0]     coord_wide;
      logic [COORD_BITS-1:0] store_ff [P];
      logic [W-1:0]          row_ff   [P];
      logic [W-1:0]          row_in   [P];
      logic [W-1:0]          up1      [P];
      logic [W-1:0]          up2      [P];
      logic signed [W:0]     diff;
      logic [W-1:0]          a_ff;
      logic signed [W-16:0]  q_ff;
      logic [15:0]           rr_ff;
      logic signed [W+2:0]   pq_ff;
      logic [32:0]           pr_ff;
      logic [33:0]           rsum;
      logic [W-1:0]          lerp_res;
      logic [W-1:0]          diff_res;
      logic [W-1:0]          res;
      logic [OUT_W-1:0]      sat_v;
      logic [OUT_W-1:0]      out_ff;

      assign coord_wide = {{(WIDE_W-IN_W){1'b0}}, coord_in[g]};

      always_ff @(posedge clock) begin
         for (int k = 0; k < P; k++) begin
            if (cmd.store_wr && int'(req_point_index) == k) begin
               store_ff[k] <= coord_wide[COORD_BITS-1:0];
            end
         end
      end

      assign diff = $signed({row_ff[1][W-1], row_ff[1]}) - $signed({row_ff[0][W-1], row_ff[0]});

      always_ff @(posedge clock) begin
         if (cmd.do_sub) begin
            a_ff  <= row_ff[0];
            q_ff  <= diff[W:16];
            rr_ff <= diff[15:0];
         end
         if (cmd.do_mul) begin
            pq_ff <= q_ff * $signed({1'b0, mul_op});
            pr_ff <= rr_ff * mul_op;
         end
      end

      assign rsum     = 34'(pr_ff) + 34'(ROUND_HALF);
      assign lerp_res = a_ff + pq_ff[W-1:0] + W'(rsum[33:16]);
      assign diff_res = {pq_ff[W-17:0], 16'b0} + W'(pr_ff);
      assign res      = (cmd.op == OP_LERP) ? lerp_res : diff_res;

      for (genvar k = 0; k < P; k++) begin : g_row
         if (k + 1 < P) begin : g_up1
            assign up1[k] = row_ff[k+1];
         end else begin : g_up1_end
            assign up1[k] = '0;
         end
         if (k + 2 < P) begin : g_up2
            assign up2[k] = row_ff[k+2];
         end else begin : g_up2_end
            assign up2[k] = '0;
         end

         always_comb begin
            row_in[k] = row_ff[k];
            if (cmd.load_row) begin
               row_in[k] = {{(W-COORD_BITS){store_ff[k][COORD_BITS-1]}}, store_ff[k]};
            end else if (cmd.do_add) begin
               if (int'(cmd.wr_pos) == k) begin
                  row_in[k] = res;
               end else if (cmd.shift2) begin
                  row_in[k] = up2[k];
               end else begin
                  row_in[k] = up1[k];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         row_ff <= row_in;
      end

      if (W <= OUT_W) begin : g_fit
         assign sat_v = OUT_W'($signed(row_ff[0]));
      end else begin : g_clamp
         logic [W-OUT_W:0] hi;
         assign hi    = row_ff[0][W-1:OUT_W-1];
         assign sat_v = ((&hi) || !(|hi)) ? row_ff[0][OUT_W-1:0] :
                        (row_ff[0][W-1] ? OUT_MIN : OUT_MAX);
      end

      always_ff @(posedge clock) begin
         if (cmd.load_out) begin
            out_ff <= cmd.zero_out ? '0 : sat_v;
         end
      end

      assign lane_out[g] = out_ff;
   end

endmodule

[hdl/bezier_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier evaluator sequencer
// Accepts transactions, plans the difference and interpolation passes and
// steps the datapath through subtract, multiply and add for each step.
// ----------------------------------------------------------------------------
module bezier_ctrl #(
   parameter int MAX_POINTS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [1:0]                   req_deriv_order,
   input  logic [bezier_pkg::CNT_W-1:0] point_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output bezier_pkg::cmd_type          cmd
);
   import bezier_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_MUL,
      ST_ADD,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [1:0]         diff_left_ff, diff_left_in;
   logic               order2_ff, order2_in;
   logic               zero_ff, zero_in;

   logic [CNT_W-1:0]   cnt;
   logic [CNT_W-1:0]   n_acc;
   logic               accept;
   logic               last;
   logic [1:0]         dl_next;
   logic [SCALE_W-1:0] nn1;

   always_comb begin
      cnt = point_count;
      if (MAX_POINTS < 15 && int'(point_count) > MAX_POINTS) begin
         cnt = CNT_W'(MAX_POINTS);
      end
      if (cnt < CNT_W'(2)) begin
         cnt = CNT_W'(2);
      end
   end

   assign n_acc     = cnt - CNT_W'(1);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign last      = (step_ff == len_ff - CNT_W'(2));
   assign dl_next   = (diff_left_ff != 2'd0) ? diff_left_ff - 2'd1 : 2'd0;
   assign nn1       = SCALE_W'(n_ff) * (SCALE_W'(n_ff) - SCALE_W'(1));

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      len_in       = len_ff;
      step_in      = step_ff;
      n_in         = n_ff;
      diff_left_in = diff_left_ff;
      order2_in    = order2_ff;
      zero_in      = zero_ff;

      cmd          = '0;
      cmd.op       = (diff_left_ff != 2'd0) ? OP_DIFF : OP_LERP;
      cmd.scale    = (diff_left_ff == 2'd2) ? SCALE_W'(1) :
                     (order2_ff ? nn1 : SCALE_W'(n_ff));
      cmd.zero_out = zero_ff;
      cmd.wr_pos   = last ? len_ff - CNT_W'(2) : len_ff - CNT_W'(1);
      cmd.shift2   = last;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_LOAD) begin
                  cmd.store_wr = 1'b1;
               end else begin
                  cmd.load_row = 1'b1;
                  len_in       = cnt;
                  step_in      = '0;
                  n_in         = n_acc;
                  order2_in    = (req_deriv_order == ORDER_SECOND);
                  zero_in      = 1'b0;
                  diff_left_in = 2'd0;
                  unique case (req_deriv_order)
                     ORDER_POINT: begin
                        state_in = ST_SUB;
                     end
                     ORDER_FIRST: begin
                        diff_left_in = 2'd1;
                        state_in     = ST_SUB;
                     end
                     ORDER_SECOND: begin
                        if (n_acc < CNT_W'(2)) begin
                           zero_in  = 1'b1;
                           state_in = ST_FINISH;
                        end else begin
                           diff_left_in = 2'd2;
                           state_in     = ST_SUB;
                        end
                     end
                     default: begin
                        zero_in  = 1'b1;
                        state_in = ST_FINISH;
                     end
                  endcase
               end
            end
         end
         ST_SUB: begin
            cmd.do_sub = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            cmd.do_add = 1'b1;
            if (!last) begin
               step_in  = step_ff + CNT_W'(1);
               state_in = ST_SUB;
            end else begin
               step_in      = '0;
               len_in       = len_ff - CNT_W'(1);
               diff_left_in = dl_next;
               if (len_ff == CNT_W'(2) && dl_next == 2'd0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SUB;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         diff_left_ff <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         diff_left_ff <= diff_left_in;
      end
      len_ff       <= len_in;
      step_ff      <= step_in;
      n_ff         <= n_in;
      order2_ff    <= order2_in;
      zero_ff      <= zero_in;
   end

`ifndef SYNTHESIS
   a_len_valid : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUB || state_ff == ST_MUL || state_ff == ST_ADD) |->
      len_ff >= CNT_W'(2))
      else $error("Pass length below two while stepping.");

   a_step_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUB || state_ff == ST_MUL || state_ff == ST_ADD) |->
      step_ff <= len_ff - CNT_W'(2))
      else $error("Step counter ran past the end of the pass.");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("Result register overwritten before the transaction completed.");

   a_diff_passes : assert property (@(posedge clock) disable iff (reset)
      diff_left_ff != 2'd3)
      else $error("More than two difference passes pending.");

   a_zero_path : assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_EVAL && req_deriv_order == ORDER_NONE) |=>
      (state_ff == ST_FINISH && zero_ff))
      else $error("Unsupported order did not go straight to a zero result.");
`endif

endmodule

[hdl/bezier_curve_point_and_derivatives_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve point and derivative evaluator
// Holds up to MAX_POINTS 3D control points and returns the point, first or
// second derivative of the curve at parameter t by de Casteljau stepping.
// ----------------------------------------------------------------------------
// A load transaction writes one control point. An evaluate transaction
// runs on one subtract, multiply and add unit per coordinate, and each
// arithmetic step passes through the subtract, multiply and add states in
// turn. With degree n = count - 1 the step count S is n(n+1)/2 for the
// point, n + n(n-1)/2 for the first derivative and 2n - 1 + (n-1)(n-2)/2
// for the second derivative. Zero results (order three, or the second
// derivative of a line) skip the steps and go straight to the finish state.
// A new transaction is accepted while the previous result still waits in
// the output register. Control points read before being written give
// undefined results; there is no clearing pass after reset.
module bezier_curve_point_and_derivatives_top #(
   parameter int MAX_POINTS = 8,
   parameter int COORD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [bezier_pkg::IDX_IN_W-1:0]   req_point_index,
   input  logic [bezier_pkg::IN_W-1:0]       req_coord_x,
   input  logic [bezier_pkg::IN_W-1:0]       req_coord_y,
   input  logic [bezier_pkg::IN_W-1:0]       req_coord_z,
   input  logic [bezier_pkg::T_W-1:0]        req_param_t,
   input  logic [1:0]                        req_deriv_order,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bezier_pkg::OUT_W-1:0]      rsp_out_x,
   output logic [bezier_pkg::OUT_W-1:0]      rsp_out_y,
   output logic [bezier_pkg::OUT_W-1:0]      rsp_out_z,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [2:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import bezier_pkg::*;

   localparam logic REG_POINT_COUNT = 1'b0;

   logic [CNT_W-1:0] point_count_ff, point_count_in;
   logic             csr_wr;
   cmd_type          cmd;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      point_count_in = point_count_ff;
      if (csr_wr && paddr[2] == REG_POINT_COUNT) begin
         point_count_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= CNT_W'(2);
      end else begin
         point_count_ff <= point_count_in;
      end
   end

   assign prdata = (paddr[2] == REG_POINT_COUNT) ? 32'(point_count_ff) : '0;

   bezier_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_deriv_order (req_deriv_order),
      .point_count     (point_count_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .cmd             (cmd)
   );

   bezier_dp #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .req_point_index (req_point_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_param_t     (req_param_t),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z)
   );

endmodule
